// File: hdl/block_energy_beat_detector_macros.svh
// assertion macros for the block energy beat detector
`ifndef BLOCK_ENERGY_BEAT_DETECTOR_MACROS_SVH
`define BLOCK_ENERGY_BEAT_DETECTOR_MACROS_SVH

`ifndef SYNTHESIS
`define BEBD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("bebd assertion failed");
`define BEBD_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("bebd forbidden condition");
`else
`define BEBD_ASSERT(lbl, clk, rstn, prop)
`define BEBD_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// File: hdl/bebd_pkg.sv
// constants and types shared by the block energy beat detector
package bebd_pkg;

    localparam int BLOCKS      = 30;
    localparam int SPW_W       = 18;
    localparam int SAMPLE_W    = 16;
    localparam int SQ_W        = 2 * SAMPLE_W;
    localparam int ACC_W       = 44;
    localparam int IDX_W       = $clog2(BLOCKS);
    localparam int BLK_CNT_W   = $clog2(BLOCKS + 1);
    localparam int WSUM_W      = ACC_W + $clog2(BLOCKS);
    localparam int BSIZE_W     = SPW_W - ($clog2(BLOCKS + 1) - 1);
    localparam int OUT_IDX_W   = 6;
    localparam int BEATS_W     = 7;
    localparam int TOTAL_W     = 32;
    localparam int SPW_RESET   = 44100;

    // reciprocal for the block size: exact for every 18-bit window length
    localparam int DIV_SHIFT   = SPW_W + $clog2(BLOCKS);
    localparam int DIV_MUL_W   = DIV_SHIFT - ($clog2(BLOCKS + 1) - 1) + 1;
    localparam longint DIV_MUL_VAL = ((64'd1 << DIV_SHIFT) + BLOCKS - 1) / BLOCKS;
    localparam logic [DIV_MUL_W-1:0] DIV_MUL = DIV_MUL_W'(DIV_MUL_VAL);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ACC,
        S_RD,
        S_LOAD
    } state_t;

endpackage

// File: hdl/bebd_ram.sv
// generic single-write, single-read ram with registered read
module bebd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hdl/block_energy_beat_detector.sv
// top level of the block energy beat detector
// each sample beat: left square on accept, right square and accumulate next; no new sample is taken meanwhile
// a window-ending sample passes the accumulate, read and load states to its first result, then one result
// per cycle while m_ready stays high; input resumes once the last result is registered
// throughput is set by the shared 16x16 squarer and the single read port of the block store
// synchronous reset clears counters and sums and loads a window of 44100; store is not cleared
`include "block_energy_beat_detector_macros.svh"
module block_energy_beat_detector
    import bebd_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [SPW_W-1:0]           cfg_samples_per_window,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_left_sample,
    input  logic signed [SAMPLE_W-1:0] s_right_sample,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [OUT_IDX_W-1:0]       m_block_index,
    output logic                       m_beat_flag,
    output logic [ACC_W-1:0]           m_block_energy,
    output logic [BEATS_W-1:0]         m_beats_in_window,
    output logic [TOTAL_W-1:0]         m_total_beats,
    output logic [TOTAL_W-1:0]         m_windows_done,
    output logic                       m_last_of_window
);

    state_t state_reg, state_next;

    logic [SPW_W-1:0]           spw_reg;
    logic [BSIZE_W-1:0]         bsize_reg;
    logic [SQ_W-1:0]            sql_reg;
    logic signed [SAMPLE_W-1:0] r_reg;
    logic [SPW_W-1:0]           wcnt_reg;
    logic [BSIZE_W-1:0]         bcnt_reg;
    logic [BLK_CNT_W-1:0]       cur_blk_reg;
    logic [ACC_W-1:0]           acc_reg;
    logic [WSUM_W-1:0]          wsum_reg;
    logic [TOTAL_W-1:0]         beat_total_reg;
    logic [TOTAL_W-1:0]         win_total_reg;
    logic [IDX_W-1:0]           k_reg;
    logic [BEATS_W-1:0]         win_beats_reg;
    logic                       m_valid_reg;
    logic [OUT_IDX_W-1:0]       m_idx_reg;
    logic                       m_beat_reg;
    logic [ACC_W-1:0]           m_energy_reg;
    logic [BEATS_W-1:0]         m_beats_reg;
    logic [TOTAL_W-1:0]         m_total_reg;
    logic [TOTAL_W-1:0]         m_windows_reg;
    logic                       m_last_reg;

    logic                       accept;
    logic                       cfg_write;
    logic                       out_free;
    logic                       load;
    logic                       last_k;
    logic                       in_block;
    logic                       blk_done;
    logic                       win_end;
    logic signed [SAMPLE_W-1:0] sq_src;
    logic signed [SQ_W-1:0]     sq_s;
    logic [SQ_W-1:0]            sq_u;
    logic [SQ_W:0]              e_sum;
    logic [ACC_W:0]             acc_sum;
    logic [ACC_W-1:0]           acc_sat;
    logic [BSIZE_W:0]           bcnt_inc;
    logic [SPW_W:0]             wcnt_inc;
    logic [SPW_W+DIV_MUL_W-1:0] div_prod;
    logic                       ram_wr;
    logic                       ram_rd;
    logic [IDX_W-1:0]           ram_raddr;
    logic [ACC_W-1:0]           ram_rdata;
    logic                       entry_valid;
    logic [ACC_W-1:0]           en;
    logic [WSUM_W-1:0]          en_scaled;
    logic                       beat;
    logic [BEATS_W-1:0]         win_beats_inc;
    logic [TOTAL_W-1:0]         beat_total_inc;

    // shared squarer: left on accept, right in the accumulate cycle
    assign sq_src   = (state_reg == S_IDLE) ? s_left_sample : r_reg;
    assign sq_s     = sq_src * sq_src;
    assign sq_u     = SQ_W'(sq_s);
    assign e_sum    = {1'b0, sql_reg} + {1'b0, sq_u};
    assign acc_sum  = {1'b0, acc_reg} + (ACC_W + 1)'(e_sum);
    assign acc_sat  = acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
    assign bcnt_inc = {1'b0, bcnt_reg} + (BSIZE_W + 1)'(1);
    assign wcnt_inc = {1'b0, wcnt_reg} + (SPW_W + 1)'(1);
    assign div_prod = (SPW_W + DIV_MUL_W)'(cfg_samples_per_window)
                      * (SPW_W + DIV_MUL_W)'(DIV_MUL);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_ACC;
                end
            end
            S_ACC: begin
                state_next = win_end ? S_RD : S_IDLE;
            end
            S_RD: begin
                state_next = S_LOAD;
            end
            S_LOAD: begin
                if (load && last_k) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb begin
        cfg_ready = 1'b1;
        cfg_write = cfg_valid;
        s_ready   = (state_reg == S_IDLE);
        accept    = s_valid && s_ready;
        out_free  = !m_valid_reg || m_ready;
        load      = (state_reg == S_LOAD) && out_free;
        last_k    = (k_reg == IDX_W'(BLOCKS - 1));
        in_block  = (cur_blk_reg < BLK_CNT_W'(BLOCKS)) && (bsize_reg != '0);
        blk_done  = (state_reg == S_ACC) && in_block && (bcnt_inc >= {1'b0, bsize_reg});
        win_end   = (state_reg == S_ACC) && (wcnt_inc >= {1'b0, spw_reg});
        ram_wr    = blk_done;
        ram_rd    = (state_reg == S_RD) || (load && !last_k);
        ram_raddr = (state_reg == S_RD) ? k_reg : k_reg + IDX_W'(1);
    end

    // beat decision on the entry just read
    assign entry_valid    = BLK_CNT_W'(k_reg) < cur_blk_reg;
    assign en             = entry_valid ? ram_rdata : '0;
    assign en_scaled      = WSUM_W'(en) * WSUM_W'(BLOCKS);
    assign beat           = entry_valid && (en_scaled > wsum_reg);
    assign win_beats_inc  = win_beats_reg + BEATS_W'(beat);
    assign beat_total_inc = (beat && (beat_total_reg != {TOTAL_W{1'b1}}))
                            ? beat_total_reg + TOTAL_W'(1) : beat_total_reg;

    bebd_ram #(
        .WIDTH(ACC_W),
        .DEPTH(BLOCKS)
    ) u_store (
        .clk    (aclk),
        .wr_en  (ram_wr),
        .wr_addr(cur_blk_reg[IDX_W-1:0]),
        .wr_data(acc_sat),
        .rd_en  (ram_rd),
        .rd_addr(ram_raddr),
        .rd_data(ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            spw_reg        <= SPW_W'(SPW_RESET);
            bsize_reg      <= BSIZE_W'(SPW_RESET / BLOCKS);
            wcnt_reg       <= '0;
            bcnt_reg       <= '0;
            cur_blk_reg    <= '0;
            acc_reg        <= '0;
            wsum_reg       <= '0;
            beat_total_reg <= '0;
            win_total_reg  <= '0;
            k_reg          <= '0;
            win_beats_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_write) begin
                spw_reg   <= cfg_samples_per_window;
                bsize_reg <= div_prod[DIV_SHIFT +: BSIZE_W];
            end
            if (state_reg == S_ACC) begin
                if (in_block) begin
                    if (blk_done) begin
                        wsum_reg    <= wsum_reg + WSUM_W'(acc_sat);
                        cur_blk_reg <= cur_blk_reg + BLK_CNT_W'(1);
                        acc_reg     <= '0;
                        bcnt_reg    <= '0;
                    end else begin
                        acc_reg  <= acc_sat;
                        bcnt_reg <= bcnt_inc[BSIZE_W-1:0];
                    end
                end
                if (win_end) begin
                    wcnt_reg      <= '0;
                    acc_reg       <= '0;
                    bcnt_reg      <= '0;
                    k_reg         <= '0;
                    win_beats_reg <= '0;
                    if (win_total_reg != {TOTAL_W{1'b1}}) begin
                        win_total_reg <= win_total_reg + TOTAL_W'(1);
                    end
                end else begin
                    wcnt_reg <= wcnt_inc[SPW_W-1:0];
                end
            end
            if (load) begin
                k_reg          <= k_reg + IDX_W'(1);
                win_beats_reg  <= win_beats_inc;
                beat_total_reg <= beat_total_inc;
                if (last_k) begin
                    cur_blk_reg <= '0;
                    wsum_reg    <= '0;
                end
            end
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            sql_reg <= sq_u;
            r_reg   <= s_right_sample;
        end
        if (load) begin
            m_idx_reg     <= OUT_IDX_W'(k_reg);
            m_beat_reg    <= beat;
            m_energy_reg  <= en;
            m_beats_reg   <= win_beats_inc;
            m_total_reg   <= beat_total_inc;
            m_windows_reg <= win_total_reg;
            m_last_reg    <= last_k;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_block_index     = m_idx_reg;
    assign m_beat_flag       = m_beat_reg;
    assign m_block_energy    = m_energy_reg;
    assign m_beats_in_window = m_beats_reg;
    assign m_total_beats     = m_total_reg;
    assign m_windows_done    = m_windows_reg;
    assign m_last_of_window  = m_last_reg;

    `BEBD_ASSERT(a_accept_then_acc, aclk, aresetn, accept |=> (state_reg == S_ACC) && !s_ready)
    `BEBD_ASSERT(a_win_end_clears, aclk, aresetn, win_end |=> (state_reg == S_RD) && (wcnt_reg == '0))
    `BEBD_ASSERT(a_last_load_idle, aclk, aresetn, (load && last_k) |=> (state_reg == S_IDLE) && (cur_blk_reg == '0) && (wsum_reg == '0))
    `BEBD_NEVER(a_blk_count_range, aclk, aresetn, cur_blk_reg > BLK_CNT_W'(BLOCKS))
    `BEBD_ASSERT(a_beats_bound, aclk, aresetn, m_valid |-> (m_beats_in_window <= (BEATS_W'(m_block_index) + BEATS_W'(1))))

endmodule

// File: tb/tb_top.sv
// self-checking testbench for the block energy beat detector
`timescale 1ns / 100ps

module tb_top;
    import bebd_pkg::*;

    localparam int unsigned STALL_LIMIT   = 2000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned RANDOM_ITEMS  = 132;
    localparam int unsigned LONG_SAMPLES  = 12;
    localparam logic [ACC_W-1:0] ENERGY_MAX = '1;
    localparam logic [SAMPLE_W-1:0] EDGE_LEVELS [4] = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000};

    typedef longint unsigned u64_t;
    typedef enum {AMP_FULL, AMP_QUIET, AMP_EDGE, AMP_SILENT} amp_style_t;
    typedef enum {RX_OPEN, RX_COIN, RX_MOSTLY, RX_CHOKED} rx_style_t;

    typedef struct {
        logic [OUT_IDX_W-1:0] block_index;
        logic                 beat_flag;
        logic [ACC_W-1:0]     block_energy;
        logic [BEATS_W-1:0]   beats_in_window;
        logic [TOTAL_W-1:0]   total_beats;
        logic [TOTAL_W-1:0]   windows_done;
        logic                 last_of_window;
    } block_report_t;

    class beat_scoreboard;
        logic [SPW_W-1:0]   window_len;
        logic [SPW_W-1:0]   window_fill;
        logic [SPW_W-1:0]   block_fill;
        int unsigned        blocks_closed;
        logic [ACC_W-1:0]   energy_acc;
        logic [ACC_W-1:0]   block_energy [BLOCKS];
        logic [WSUM_W-1:0]  window_energy;
        logic [TOTAL_W-1:0] beat_total;
        logic [TOTAL_W-1:0] window_total;
        block_report_t      expected_reports [$];
        int unsigned        samples_seen;
        int unsigned        reports_checked;
        int unsigned        fail_count;

        function new();
            window_len      = SPW_W'(SPW_RESET);
            window_fill     = '0;
            block_fill      = '0;
            blocks_closed   = 0;
            energy_acc      = '0;
            window_energy   = '0;
            beat_total      = '0;
            window_total    = '0;
            samples_seen    = 0;
            reports_checked = 0;
            fail_count      = 0;
        endfunction

        function void set_window(logic [SPW_W-1:0] len);
            window_len = len;
        endfunction

        function int unsigned pending();
            return expected_reports.size();
        endfunction

        function void note_sample(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r);
            longint           ls;
            longint           rs;
            u64_t             acc_sum;
            logic [SPW_W-1:0] blk_len;
            int unsigned      beats;
            block_report_t    rep;
            ls = l;
            rs = r;
            blk_len = window_len / BLOCKS;
            samples_seen++;
            if (blocks_closed < BLOCKS && blk_len != 0) begin
                acc_sum = u64_t'(energy_acc) + u64_t'(ls * ls + rs * rs);
                energy_acc = (acc_sum > u64_t'(ENERGY_MAX)) ? ENERGY_MAX : ACC_W'(acc_sum);
                block_fill++;
                if (block_fill >= blk_len) begin
                    block_energy[blocks_closed] = energy_acc;
                    window_energy += energy_acc;
                    blocks_closed++;
                    energy_acc = '0;
                    block_fill = '0;
                end
            end
            window_fill++;
            if (window_fill >= window_len) begin
                beats = 0;
                if (window_total != '1) window_total++;
                for (int k = 0; k < BLOCKS; k++) begin
                    rep.block_energy = (k < blocks_closed) ? block_energy[k] : '0;
                    rep.beat_flag = (k < blocks_closed) &&
                        (u64_t'(rep.block_energy) * u64_t'(BLOCKS) > u64_t'(window_energy));
                    if (rep.beat_flag) begin
                        beats++;
                        if (beat_total != '1) beat_total++;
                    end
                    rep.block_index     = OUT_IDX_W'(k);
                    rep.beats_in_window = BEATS_W'(beats);
                    rep.total_beats     = beat_total;
                    rep.windows_done    = window_total;
                    rep.last_of_window  = (k == BLOCKS - 1);
                    expected_reports = {expected_reports, rep};
                end
                window_fill   = '0;
                block_fill    = '0;
                blocks_closed = 0;
                energy_acc    = '0;
                window_energy = '0;
            end
        endfunction

        function void check_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                fail_count++;
            end
        endfunction

        function void check_block_report(block_report_t got);
            block_report_t want;
            if (expected_reports.size() == 0) begin
                $error("block report with nothing expected: block %0d energy %0d",
                       got.block_index, got.block_energy);
                fail_count++;
                return;
            end
            want = expected_reports.pop_front();
            reports_checked++;
            check_field("block_index", 64'(want.block_index), 64'(got.block_index));
            check_field("beat_flag", 64'(want.beat_flag), 64'(got.beat_flag));
            check_field("block_energy", 64'(want.block_energy), 64'(got.block_energy));
            check_field("beats_in_window", 64'(want.beats_in_window), 64'(got.beats_in_window));
            check_field("total_beats", 64'(want.total_beats), 64'(got.total_beats));
            check_field("windows_done", 64'(want.windows_done), 64'(got.windows_done));
            check_field("last_of_window", 64'(want.last_of_window), 64'(got.last_of_window));
        endfunction
    endclass

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [SPW_W-1:0]           cfg_samples_per_window = '0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_left_sample = '0;
    logic signed [SAMPLE_W-1:0] s_right_sample = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [OUT_IDX_W-1:0]       m_block_index;
    logic                       m_beat_flag;
    logic [ACC_W-1:0]           m_block_energy;
    logic [BEATS_W-1:0]         m_beats_in_window;
    logic [TOTAL_W-1:0]         m_total_beats;
    logic [TOTAL_W-1:0]         m_windows_done;
    logic                       m_last_of_window;

    beat_scoreboard sb = new();
    block_report_t  seen_report;
    int unsigned    burst_left = 0;
    int unsigned    settings_written = 0;
    int unsigned    idle_cycles = 0;
    int unsigned    rx_span = 0;
    rx_style_t      rx_style = RX_OPEN;
    amp_style_t     amp_style = AMP_FULL;

    block_energy_beat_detector DUT (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .cfg_valid              (cfg_valid),
        .cfg_ready              (cfg_ready),
        .cfg_samples_per_window (cfg_samples_per_window),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_left_sample          (s_left_sample),
        .s_right_sample         (s_right_sample),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_block_index          (m_block_index),
        .m_beat_flag            (m_beat_flag),
        .m_block_energy         (m_block_energy),
        .m_beats_in_window      (m_beats_in_window),
        .m_total_beats          (m_total_beats),
        .m_windows_done         (m_windows_done),
        .m_last_of_window       (m_last_of_window)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // receiver stall pattern, changing style after each random span
    always @(posedge aclk) begin
        if (rx_span == 0) begin
            rx_span  = $urandom_range(4, 40);
            rx_style = rx_style_t'($urandom_range(0, 3));
        end
        rx_span--;
        case (rx_style)
            RX_OPEN:   m_ready <= 1'b1;
            RX_COIN:   m_ready <= ($urandom_range(0, 1) == 1);
            RX_MOSTLY: m_ready <= ($urandom_range(0, 3) != 0);
            default:   m_ready <= ((rx_span % 8) < 2);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                seen_report = '{m_block_index, m_beat_flag, m_block_energy, m_beats_in_window,
                                m_total_beats, m_windows_done, m_last_of_window};
                sb.check_block_report(seen_report);
            end
            if (cfg_valid && cfg_ready) sb.set_window(cfg_samples_per_window);
            if (s_valid && s_ready) sb.note_sample(s_left_sample, s_right_sample);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("block_energy_beat_detector regression: fail");
            $finish;
        end
    end

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] l,
                               input logic signed [SAMPLE_W-1:0] r);
        int unsigned gap;
        s_valid        <= 1'b1;
        s_left_sample  <= l;
        s_right_sample <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 10);
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 30) : $urandom_range(0, 5);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // sender holds off until every block report has been taken
    task automatic wait_drained();
        if (s_valid) s_valid <= 1'b0;
        @(negedge aclk);
        while (sb.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_window(input logic [SPW_W-1:0] len);
        wait_drained();
        cfg_valid              <= 1'b1;
        cfg_samples_per_window <= len;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        settings_written++;
    endtask

    task automatic pick_sample(output logic signed [SAMPLE_W-1:0] l,
                               output logic signed [SAMPLE_W-1:0] r);
        if ($urandom_range(0, 7) == 0) amp_style = amp_style_t'($urandom_range(0, 3));
        case (amp_style)
            AMP_FULL: begin
                l = SAMPLE_W'($urandom);
                r = SAMPLE_W'($urandom);
            end
            AMP_QUIET: begin
                l = SAMPLE_W'($urandom_range(0, 255) - 128);
                r = SAMPLE_W'($urandom_range(0, 255) - 128);
            end
            AMP_EDGE: begin
                l = EDGE_LEVELS[$urandom_range(0, 3)];
                r = EDGE_LEVELS[$urandom_range(0, 3)];
            end
            default: begin
                l = '0;
                r = '0;
            end
        endcase
    endtask

    initial begin
        logic signed [SAMPLE_W-1:0] l;
        logic signed [SAMPLE_W-1:0] r;
        logic [SPW_W-1:0]           len;
        int unsigned                random_items;
        int unsigned                room;
        int unsigned                span;
        random_items = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // default length, then zero length mid-window ends it on the next beat
        send_sample(16'h8000, 16'h7FFF);
        send_sample(16'h7FFF, 16'h8000);
        write_window('0);
        send_sample(16'h0000, 16'hFFFF);

        // one-sample blocks with two remainder samples
        write_window(SPW_W'(32));
        for (int i = 0; i < 32; i++) begin
            l = EDGE_LEVELS[i % 4];
            r = (i % 3 == 0) ? EDGE_LEVELS[(i / 4) % 4] : SAMPLE_W'(i * 517 - 8000);
            send_sample(l, r);
        end

        // full-scale beats in a maximum-length window, then a shorter length takes over mid-window
        write_window('1);
        repeat (LONG_SAMPLES) send_sample(16'h8000, 16'h8000);
        write_window(SPW_W'(60));
        send_sample(16'h8000, 16'h8000);

        while (random_items < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       len = SPW_W'($urandom_range(0, 29));
                1:       len = SPW_W'($urandom_range(100, 200));
                default: len = SPW_W'($urandom_range(30, 90));
            endcase
            write_window(len);
            room = (len > sb.window_fill) ? len - sb.window_fill : 1;
            span = ($urandom_range(0, 3) == 0) ? $urandom_range(1, room) : room;
            if (span > RANDOM_ITEMS - random_items) span = RANDOM_ITEMS - random_items;
            repeat (span) begin
                pick_sample(l, r);
                send_sample(l, r);
            end
            random_items += span;
        end

        wait_drained();
        $display("drove %0d samples over %0d window lengths, checked %0d block reports",
                 sb.samples_seen, settings_written, sb.reports_checked);
        $display("covered zero and maximum lengths, short windows, remainders, "
                 , "mid-window length changes and full-scale samples");
        if (sb.fail_count == 0 && sb.pending() == 0) begin
            $display("block_energy_beat_detector regression: pass");
        end else begin
            $display("block_energy_beat_detector regression: fail");
        end
        $finish;
    end
endmodule

// File: sim.f
+incdir+hdl
hdl/bebd_pkg.sv
hdl/bebd_ram.sv
hdl/block_energy_beat_detector.sv
tb/tb_top.sv
